// ===== design/abe_pkg.sv =====
// Shared types, constants and helpers for the allocation bitmap engine.
package abe_pkg;

  localparam int MAP_WORDS_DEFAULT = 1024;
  localparam int FIELD_WORDS       = 1024;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [4:0]  BIT_MASK = 5'h1F;

  localparam logic [10:0] WORD_COUNT_RESET = 11'd1024;
  localparam logic [0:0]  REG_WORD_COUNT   = 1'b0;

  typedef enum logic [1:0] {
    MODE_FIND_SET = 2'd0,
    MODE_FIND_CLR = 2'd1,
    MODE_SET_RUN  = 2'd2,
    MODE_CLR_RUN  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // MSB-first index of the first set bit; v must be nonzero
  function automatic logic [4:0] lead_pos(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(31 - i);
      end
    end
    return p;
  endfunction

endpackage

// ===== design/allocation_bitmap_engine.sv =====
// Top level of the allocation bitmap engine: ports, register block, sequencer and bitmap RAM.
// The bitmap lives in one RAM of MAP_WORDS 32-bit words with a registered read port.
// After reset a clearing pass writes zero to every word, one word a cycle; in_tready stays
// low until it ends (register writes are taken throughout). Each accepted request then walks
// the bitmap words, one per cycle through the RAM read port (a search stops at the word
// holding the hit; a run touches every word it covers), and its result word then enters the
// output register. A run with a zero count, or any request with an offset at or beyond the
// end of the region, skips the walk and goes straight to the result load. in_tready returns
// once the result is loaded, so a new request is not taken before the last one's result is
// loaded; the load waits while the previous result still sits unaccepted on the output side,
// but the next request is taken while that result waits.
module allocation_bitmap_engine #(
  parameter int MAP_WORDS = abe_pkg::MAP_WORDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // bit_offset[14:0], bit_count[30:15], zero
  input  logic [1:0]  in_tuser,    // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // position[14:0], bits_done[30:15], zero
  output logic [0:0]  out_tuser,   // found[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import abe_pkg::*;

  localparam int ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [10:0]       word_count;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic              found;
  logic [14:0]       position;
  logic [15:0]       bits_done;

  abe_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .word_count  (word_count)
  );

  abe_ctrl #(
    .MAP_WORDS (MAP_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_count    (word_count),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_mode       (mode_t'(in_tuser)),
    .in_offset     (in_tdata[14:0]),
    .in_count      (in_tdata[30:15]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_found     (found),
    .out_position  (position),
    .out_bits_done (bits_done),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  abe_ram #(
    .WIDTH  (32),
    .DEPTH  (MAP_WORDS),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {1'b0, bits_done, position};
  assign out_tuser = found;

endmodule

// ===== design/abe_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module abe_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/abe_regs.sv =====
// Configuration register block behind the APB-style port.
module abe_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [10:0] word_count
);
  import abe_pkg::*;

  logic [10:0] word_count_r;
  logic [10:0] word_count_nxt;
  logic        wr_en;
  logic        sel_wc;

  assign sel_wc = (cfg_paddr[2] == REG_WORD_COUNT);
  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    word_count_nxt = word_count_r;
    if (wr_en && sel_wc) begin
      word_count_nxt = cfg_pwdata[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= WORD_COUNT_RESET;
    end else begin
      word_count_r <= word_count_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_wc ? {21'd0, word_count_r} : 32'd0;
  assign word_count = word_count_r;

endmodule

// ===== design/abe_ctrl.sv =====
// Request sequencer: clearing pass, word walk over the bitmap RAM, result register.
module abe_ctrl #(
  parameter int MAP_WORDS = abe_pkg::MAP_WORDS_DEFAULT,
  parameter int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [10:0]       word_count,
  input  logic              in_valid,
  output logic              in_ready,
  input  abe_pkg::mode_t    in_mode,
  input  logic [14:0]       in_offset,
  input  logic [15:0]       in_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [14:0]       out_position,
  output logic [15:0]       out_bits_done,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [31:0]       ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [31:0]       ram_rdata
);
  import abe_pkg::*;

  localparam int          LIMIT      = (MAP_WORDS < FIELD_WORDS) ? MAP_WORDS : FIELD_WORDS;
  localparam logic [10:0] LIMIT_W    = 11'(LIMIT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  mode_t             mode_r, mode_nxt;
  logic [9:0]        ev_w_r, ev_w_nxt;
  logic [9:0]        stop_w_r, stop_w_nxt;
  logic              first_r, first_nxt;
  logic [4:0]        first_bit_r, first_bit_nxt;
  logic [4:0]        end_bit_r, end_bit_nxt;
  logic              res_found_r, res_found_nxt;
  logic [14:0]       res_pos_r, res_pos_nxt;
  logic [15:0]       res_done_r, res_done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [14:0]       out_pos_r, out_pos_nxt;
  logic [15:0]       out_done_r, out_done_nxt;

  logic [10:0] region;
  logic [15:0] total;
  logic        off_ok;
  logic [15:0] room;
  logic [15:0] take;
  logic [15:0] end_pos;
  logic        accept;
  logic        is_run;
  logic        go;
  logic [31:0] head;
  logic [31:0] tail;
  logic [31:0] sv;
  logic        hit;
  logic        last_w;
  logic        out_free;
  logic [9:0]  rd_word;
  logic [ADDR_W+9:0] rd_wide;
  logic [ADDR_W+9:0] wr_wide;

  assign region  = (word_count > LIMIT_W) ? LIMIT_W : word_count;
  assign total   = {region, 5'd0};
  assign off_ok  = {1'b0, in_offset} < total;
  assign room    = total - {1'b0, in_offset};
  assign take    = (in_count < room) ? in_count : room;
  assign end_pos = {1'b0, in_offset} + take - 16'd1;
  assign is_run  = in_mode[1];
  assign go      = off_ok && (!is_run || (in_count != 16'd0));
  assign accept  = in_valid && in_ready;

  assign head   = first_r ? (ALL_ONES >> first_bit_r) : ALL_ONES;
  assign last_w = (ev_w_r == stop_w_r);
  assign tail   = last_w ? ~(ALL_ONES >> ({1'b0, end_bit_r} + 6'd1)) : ALL_ONES;
  assign sv     = ((mode_r == MODE_FIND_CLR) ? ~ram_rdata : ram_rdata) & head;
  assign hit    = (sv != 32'd0);
  assign out_free = !out_valid_r || out_ready;

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    mode_nxt      = mode_r;
    ev_w_nxt      = ev_w_r;
    stop_w_nxt    = stop_w_r;
    first_nxt     = first_r;
    first_bit_nxt = first_bit_r;
    end_bit_nxt   = end_bit_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_done_nxt  = out_done_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_nxt      = in_mode;
          ev_w_nxt      = in_offset[14:5];
          first_nxt     = 1'b1;
          first_bit_nxt = in_offset[4:0] & BIT_MASK;
          end_bit_nxt   = end_pos[4:0];
          stop_w_nxt    = is_run ? end_pos[14:5] : 10'(region - 11'd1);
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          res_done_nxt  = (is_run && go) ? take : 16'd0;
          state_nxt     = go ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (!mode_r[1] && hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = {ev_w_r, lead_pos(sv)};
          state_nxt     = ST_DONE;
        end else if (last_w) begin
          state_nxt = ST_DONE;
        end else begin
          ev_w_nxt  = ev_w_r + 10'd1;
          first_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          out_done_nxt  = res_done_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // RAM and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = '0;
    rd_word   = ev_w_r + 10'd1;
    wr_wide   = {{ADDR_W{1'b0}}, ev_w_r};
    ram_waddr = wr_wide[ADDR_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_word  = in_offset[14:5];
      end
      ST_WALK: begin
        ram_we    = mode_r[1];
        ram_wdata = (mode_r == MODE_SET_RUN) ? (ram_rdata | (head & tail))
                                             : (ram_rdata & ~(head & tail));
      end
      default: begin
      end
    endcase
    rd_wide   = {{ADDR_W{1'b0}}, rd_word};
    ram_raddr = rd_wide[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    ev_w_r      <= ev_w_nxt;
    stop_w_r    <= stop_w_nxt;
    first_r     <= first_nxt;
    first_bit_r <= first_bit_nxt;
    end_bit_r   <= end_bit_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_done_r  <= res_done_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_position  = out_pos_r;
  assign out_bits_done = out_done_r;

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (ev_w_r <= stop_w_r))
    else $error("word walk ran past its last word");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || ((state_r == ST_WALK) && mode_r[1])))
    else $error("bitmap written outside clear pass or run update");

  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_WALK) || (state_r == ST_DONE))
    else $error("accepted word did not start work");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished request");

endmodule
